/* rtl/dcwa_pkg.sv */
// ----------------------------------------------------------------------------
// dcwa_pkg
// Channel codes and types shared by the dual channel window averager.
// ----------------------------------------------------------------------------
package dcwa_pkg;

	localparam int CHAN_BITS = 5;

	typedef logic [CHAN_BITS-1:0] chan_t;

	localparam chan_t SUPPLY_CHANNEL    = chan_t'(1);
	localparam chan_t ALT_CHANNEL_RESET = chan_t'(2);

endpackage

/* rtl/dcwa_ram.sv */
// ----------------------------------------------------------------------------
// dcwa_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module dcwa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/dcwa_window.sv */
// ----------------------------------------------------------------------------
// dcwa_window
// One boxcar window: sample ring in RAM, running sum and write position.
// The entry at the write position is prefetched, so a push needs at least one
// idle cycle of this window after the previous push.
// ----------------------------------------------------------------------------
module dcwa_window #(
	parameter int DEPTH       = 256,
	parameter int SAMPLE_BITS = 10,
	parameter int SUM_BITS    = SAMPLE_BITS + $clog2(DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic [SUM_BITS-1:0]    sum_next
);

	localparam int IDX_BITS = $clog2(DEPTH);

	logic [IDX_BITS-1:0]    position_q;
	logic [IDX_BITS-1:0]    position_next;
	logic                   wrapped_q;
	logic                   last;
	logic [SUM_BITS-1:0]    sum_q;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic [SAMPLE_BITS-1:0] oldest;

	dcwa_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (push),
		.waddr(position_q),
		.wdata(sample),
		.raddr(position_q),
		.rdata(rd_data)
	);

	assign last          = (position_q == IDX_BITS'(DEPTH - 1));
	assign position_next = last ? '0 : position_q + IDX_BITS'(1);
	// entries are unwritten until the first wrap and read as zero
	assign oldest        = wrapped_q ? rd_data : '0;
	assign sum_next      = push ? (sum_q - SUM_BITS'(oldest) + SUM_BITS'(sample)) : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			wrapped_q  <= 1'b0;
			sum_q      <= '0;
		end else if (push) begin
			position_q <= position_next;
			wrapped_q  <= wrapped_q | last;
			sum_q      <= sum_next;
		end
	end

endmodule

/* rtl/dual_channel_window_averager.sv */
// ----------------------------------------------------------------------------
// dual_channel_window_averager
// Two boxcar moving averages fed by alternating converter samples.
//
//   channel  valid/ready                  payload
//   input    sample_valid/sample_ready    sample
//   result   result_valid/result_ready    took_supply, supply_average,
//                                         alternate_average, next_channel
//   config   alternate_channel_we         alternate_channel
//
// One item per cycle unless a held result stalls the input; the result appears in the cycle after acceptance.
// The ring read of each window is prefetched at its write position, which
// holds because the two windows take items in turn.
// A stalled result holds; a new item is taken in the cycle the result leaves.
// Reset clears no RAM: entries read as zero until their window first wraps.
// ----------------------------------------------------------------------------
module dual_channel_window_averager #(
	parameter int WINDOW_DEPTH = 256,
	parameter int SAMPLE_BITS  = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   alternate_channel_we,
	input  dcwa_pkg::chan_t        alternate_channel,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic                   took_supply,
	output logic [SAMPLE_BITS-1:0] supply_average,
	output logic [SAMPLE_BITS-1:0] alternate_average,
	output dcwa_pkg::chan_t        next_channel
);

	import dcwa_pkg::*;

	localparam int LOG_D    = $clog2(WINDOW_DEPTH);
	localparam int SUM_BITS = SAMPLE_BITS + LOG_D;
	localparam bit IS_POW2  = ((1 << LOG_D) == WINDOW_DEPTH);

	chan_t               alt_chan_q;
	logic                phase_q;
	logic                in_accept;
	logic                push_supply;
	logic                push_alt;
	logic [SUM_BITS-1:0] sup_sum_next;
	logic [SUM_BITS-1:0] alt_sum_next;
	logic                result_valid_q;
	logic                took_q;
	logic [SUM_BITS-1:0] sup_sum_q;
	logic [SUM_BITS-1:0] alt_sum_q;
	chan_t               next_chan_q;
	logic [SUM_BITS-1:0] sup_quot;
	logic [SUM_BITS-1:0] alt_quot;

	assign sample_ready = !result_valid_q || result_ready;
	assign in_accept    = sample_valid && sample_ready;
	assign push_supply  = in_accept && phase_q;
	assign push_alt     = in_accept && !phase_q;

	dcwa_window #(
		.DEPTH      (WINDOW_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUM_BITS   (SUM_BITS)
	) u_supply (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push_supply),
		.sample  (sample),
		.sum_next(sup_sum_next)
	);

	dcwa_window #(
		.DEPTH      (WINDOW_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUM_BITS   (SUM_BITS)
	) u_alternate (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push_alt),
		.sample  (sample),
		.sum_next(alt_sum_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_chan_q <= ALT_CHANNEL_RESET;
		end else if (alternate_channel_we) begin
			alt_chan_q <= alternate_channel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= 1'b1;
			result_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				phase_q <= !phase_q;
			end
			if (sample_ready) begin
				result_valid_q <= sample_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			took_q      <= phase_q;
			sup_sum_q   <= sup_sum_next;
			alt_sum_q   <= alt_sum_next;
			next_chan_q <= phase_q ? alt_chan_q : SUPPLY_CHANNEL;
		end
	end

	// divide the registered sums by the window depth
	if (IS_POW2) begin : g_shift
		assign sup_quot = sup_sum_q >> LOG_D;
		assign alt_quot = alt_sum_q >> LOG_D;
	end else begin : g_recip
		localparam int SHIFT      = SUM_BITS + LOG_D;
		localparam int RECIP_BITS = SUM_BITS + 1;
		localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
		localparam longint unsigned RECIP_FULL =
			((64'd1 << SHIFT) / WINDOW_DEPTH) + 64'd1;
		localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_FULL);

		logic [PROD_BITS-1:0] sup_prod;
		logic [PROD_BITS-1:0] alt_prod;

		assign sup_prod = PROD_BITS'(sup_sum_q) * PROD_BITS'(RECIP);
		assign alt_prod = PROD_BITS'(alt_sum_q) * PROD_BITS'(RECIP);
		assign sup_quot = SUM_BITS'(sup_prod >> SHIFT);
		assign alt_quot = SUM_BITS'(alt_prod >> SHIFT);
	end

	assign result_valid      = result_valid_q;
	assign took_supply       = took_q;
	assign supply_average    = SAMPLE_BITS'(sup_quot);
	assign alternate_average = SAMPLE_BITS'(alt_quot);
	assign next_channel      = next_chan_q;

	a_supply_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		push_supply |=> !push_supply)
		else $error("supply window pushed in consecutive cycles");

	a_alt_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		push_alt |=> !push_alt)
		else $error("alternate window pushed in consecutive cycles");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> result_valid_q && (took_q == $past(phase_q)))
		else $error("result missing or wrong window after accepted item");

	a_phase_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (phase_q != $past(phase_q)))
		else $error("phase did not advance on accepted item");

endmodule

/* bench/dual_channel_window_averager_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_channel_window_averager_test
// Sends converter samples through the averager and checks every result item
// against a local model of the two boxcar windows. The model tracks the
// channel turn, the rings, the sums and the alternate channel code.
// Directed items cover the reset channel code, code changes on either turn,
// full-scale and zero samples and every sample bit. Random bursts then wrap
// both windows under several channel codes, with random gaps on both sides in all but the third phase.
// ----------------------------------------------------------------------------
module dual_channel_window_averager_test;
	import dcwa_pkg::*;

	localparam int DEPTH         = 256;
	localparam int SAMPLE_W      = 10;
	localparam int SLOT_W        = 8;
	localparam int SUM_W         = SAMPLE_W + SLOT_W;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 140;
	localparam int PRINT_LIMIT   = 40;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

	typedef enum int {
		BURST_UNIFORM,
		BURST_FULL,
		BURST_EMPTY,
		BURST_HIGH
	} burst_kind_t;

	typedef struct packed {
		logic                took;
		logic [SAMPLE_W-1:0] supply_avg;
		logic [SAMPLE_W-1:0] alt_avg;
		chan_t               next;
	} window_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                alternate_channel_we;
	chan_t               alternate_channel;
	logic                sample_valid;
	logic                sample_ready;
	logic [SAMPLE_W-1:0] sample;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic                took_supply;
	logic [SAMPLE_W-1:0] supply_average;
	logic [SAMPLE_W-1:0] alternate_average;
	chan_t               next_channel;

	logic [SAMPLE_W-1:0] supply_ring [DEPTH];
	logic [SAMPLE_W-1:0] alt_ring [DEPTH];
	logic [SUM_W-1:0]    supply_total;
	logic [SUM_W-1:0]    alt_total;
	logic [SLOT_W-1:0]   supply_slot;
	logic [SLOT_W-1:0]   alt_slot;
	logic                supply_turn;
	chan_t               alt_chan_model;

	window_result_t pending_averages [$];
	int             stall_pct = 28;
	int             mismatches = 0;
	int             results_seen = 0;
	int             cycle_count = 0;

	dual_channel_window_averager #(
		.WINDOW_DEPTH(DEPTH),
		.SAMPLE_BITS (SAMPLE_W)
	) dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.alternate_channel_we(alternate_channel_we),
		.alternate_channel   (alternate_channel),
		.sample_valid        (sample_valid),
		.sample_ready        (sample_ready),
		.sample              (sample),
		.result_valid        (result_valid),
		.result_ready        (result_ready),
		.took_supply         (took_supply),
		.supply_average      (supply_average),
		.alternate_average   (alternate_average),
		.next_channel        (next_channel)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL dual_channel_window_averager");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch at result %0d: %s got %0d want %0d",
				results_seen, what, got, want);
	endtask

	function automatic window_result_t absorb_sample(input logic [SAMPLE_W-1:0] value);
		window_result_t r;
		r.took = supply_turn;
		if (supply_turn) begin
			supply_total = supply_total - SUM_W'(supply_ring[supply_slot]) + SUM_W'(value);
			supply_ring[supply_slot] = value;
			supply_slot = supply_slot + 1'b1;
			r.next = alt_chan_model;
		end else begin
			alt_total = alt_total - SUM_W'(alt_ring[alt_slot]) + SUM_W'(value);
			alt_ring[alt_slot] = value;
			alt_slot = alt_slot + 1'b1;
			r.next = SUPPLY_CHANNEL;
		end
		supply_turn = !supply_turn;
		r.supply_avg = supply_total[SUM_W-1:SLOT_W];
		r.alt_avg = alt_total[SUM_W-1:SLOT_W];
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		window_result_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (pending_averages.size() == 0) begin
				report_mismatch("unexpected item", 32'(0), 32'(0));
			end else begin
				want = pending_averages.pop_front();
				if (took_supply !== want.took)
					report_mismatch("took_supply", 32'(took_supply), 32'(want.took));
				if (supply_average !== want.supply_avg)
					report_mismatch("supply_average", 32'(supply_average),
						32'(want.supply_avg));
				if (alternate_average !== want.alt_avg)
					report_mismatch("alternate_average", 32'(alternate_average),
						32'(want.alt_avg));
				if (next_channel !== want.next)
					report_mismatch("next_channel", 32'(next_channel), 32'(want.next));
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		while ($urandom_range(0, 99) < stall_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		pending_averages.push_back(absorb_sample(value));
	endtask

	task automatic drain_results();
		sample_valid <= 1'b0;
		while (pending_averages.size() != 0) @(posedge clk);
	endtask

	task automatic write_alternate_channel(input chan_t code);
		drain_results();
		alternate_channel_we <= 1'b1;
		alternate_channel <= code;
		@(posedge clk);
		alternate_channel_we <= 1'b0;
		alt_chan_model = code;
	endtask

	task automatic test_reset_channel();
		send_sample(FULL_SCALE);
		send_sample('0);
		send_sample(FULL_SCALE);
		send_sample(FULL_SCALE);
	endtask

	// change the code on a supply turn, then on an alternate turn
	task automatic test_channel_change();
		write_alternate_channel(chan_t'(31));
		send_sample('0);
		send_sample(FULL_SCALE);
		send_sample('0);
		write_alternate_channel(chan_t'(0));
		send_sample(FULL_SCALE);
		send_sample(SAMPLE_W'(5));
	endtask

	task automatic test_sample_bits();
		for (int i = 0; i < SAMPLE_W; i++)
			send_sample(SAMPLE_W'(1) << i);
		send_sample(SAMPLE_W'('h155));
		send_sample(SAMPLE_W'('h2aa));
	endtask

	task automatic test_random_windows();
		chan_t               codes [RANDOM_PHASES];
		burst_kind_t         kind;
		int                  left;
		int                  run;
		logic [SAMPLE_W-1:0] value;
		codes = '{chan_t'(0), chan_t'(31), chan_t'($urandom), SUPPLY_CHANNEL,
			chan_t'($urandom)};
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_alternate_channel(codes[p]);
			stall_pct = (p == 2) ? 0 : 28;
			left = PHASE_ITEMS;
			while (left > 0) begin
				kind = burst_kind_t'($urandom_range(0, 3));
				run = $urandom_range(1, 40);
				for (int i = 0; i < run && left > 0; i++) begin
					case (kind)
						BURST_FULL: value = FULL_SCALE;
						BURST_EMPTY: value = '0;
						BURST_HIGH: value = SAMPLE_W'($urandom_range(960, 1023));
						default: value = SAMPLE_W'($urandom);
					endcase
					send_sample(value);
					left--;
				end
			end
		end
		stall_pct = 28;
	endtask

	initial begin
		foreach (supply_ring[i]) begin
			supply_ring[i] = '0;
			alt_ring[i] = '0;
		end
		supply_total = '0;
		alt_total = '0;
		supply_slot = '0;
		alt_slot = '0;
		supply_turn = 1'b1;
		alt_chan_model = ALT_CHANNEL_RESET;

		arst_n <= 1'b0;
		alternate_channel_we <= 1'b0;
		alternate_channel <= ALT_CHANNEL_RESET;
		sample_valid <= 1'b0;
		sample <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_channel();
		test_channel_change();
		test_sample_bits();
		test_random_windows();

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("PASS dual_channel_window_averager");
		else
			$display("FAIL dual_channel_window_averager");
		$finish;
	end

endmodule

/* dual_channel_window_averager.f */
rtl/dcwa_pkg.sv
rtl/dcwa_ram.sv
rtl/dcwa_window.sv
rtl/dual_channel_window_averager.sv
bench/dual_channel_window_averager_test.sv
